// File: rtl/wave_chunk_parser_pcm_convert_defines.svh
// Assertion macros shared by the checker.
`ifndef WAVE_CHUNK_PARSER_PCM_CONVERT_DEFINES_SVH
`define WAVE_CHUNK_PARSER_PCM_CONVERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/wcp_pkg.sv
package wcp_pkg;

	typedef enum logic [2:0] {
		PH_PREAMBLE,
		PH_HEADER,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_FORMAT,
		KIND_STATUS
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NOT_PCM,
		ST_RANGE,
		ST_NO_FORMAT,
		ST_NO_DATA
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [4:0]         bits;
		logic [15:0]        rate;
		logic [15:0]        channels;
		logic signed [15:0] sample;
		kind_t              kind;
		logic               last;
	} res_t;

	localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
	localparam logic [31:0] PREAMBLE_LEN = 32'd12;
	localparam logic [31:0] HDR_LEN      = 32'd8;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;
	localparam logic [31:0] MAX_RATE     = 32'd48000;
	localparam logic [15:0] MAX_BITS     = 16'd16;
	localparam logic [15:0] FMT_CODE_PCM = 16'd1;
	localparam logic [15:0] SMP_OFFSET   = 16'd128;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 56;
	localparam int RES_DEPTH   = 4;

endpackage

// File: rtl/wcp_parser.sv
module wcp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  logic [7:0]    in_byte,
	input  logic          eof,
	input  logic          mode,
	output wcp_pkg::res_t res0,
	output wcp_pkg::res_t res1,
	output logic [1:0]    res_cnt
);
	import wcp_pkg::*;

	phase_t      phase_q, phase_n;
	logic [31:0] cnt_q, cnt_n, cnt_inc;
	logic [31:0] tag_q, tag_n;
	logic [31:0] len_q, len_n, len_d;
	logic [15:0] code_q, code_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bits_q, bits_n;
	logic [7:0]  low_q, low_n;
	logic        have_q, have_n;

	logic pre_done, hdr_done, fmt_done, fmt_bad_code, fmt_bad_rng, fmt_ok;
	logic skip_done, data_end, smp_emit, fin_a, mid_data, mid_have, eof_fin;
	status_t st_a, st_e;

	assign cnt_inc = cnt_q + 32'd1;

	// field capture
	always_comb begin
		tag_n  = tag_q;
		len_n  = len_q;
		code_n = code_q;
		chan_n = chan_q;
		rate_n = rate_q;
		bits_n = bits_q;
		low_n  = low_q;
		case (phase_q)
			PH_HEADER: begin
				if (cnt_q == 32'd0)
					len_n = '0;
				if (!cnt_q[2])
					tag_n = {tag_q[23:0], in_byte};
				else
					len_n[{cnt_q[1:0], 3'b000} +: 8] = in_byte;
			end
			PH_FMT: begin
				if (cnt_q == 32'd0) begin
					code_n = '0;
					chan_n = '0;
					rate_n = '0;
					bits_n = '0;
				end
				if (cnt_q < 32'd2)
					code_n[{cnt_q[0], 3'b000} +: 8] = in_byte;
				else if (cnt_q < 32'd4)
					chan_n[{cnt_q[0], 3'b000} +: 8] = in_byte;
				else if (cnt_q < 32'd8)
					rate_n[{cnt_q[1:0], 3'b000} +: 8] = in_byte;
				else if (cnt_q == 32'd14 || cnt_q == 32'd15)
					bits_n[{cnt_q[0], 3'b000} +: 8] = in_byte;
			end
			PH_DATA: begin
				if (bits_q == MAX_BITS && !cnt_q[0])
					low_n = in_byte;
			end
			default: ;
		endcase
	end

	assign pre_done     = (phase_q == PH_PREAMBLE) && (cnt_inc >= PREAMBLE_LEN);
	assign hdr_done     = (phase_q == PH_HEADER) && (cnt_inc >= HDR_LEN);
	assign fmt_done     = (phase_q == PH_FMT) && (cnt_inc >= FMT_BODY_LEN);
	assign fmt_bad_code = (code_n != FMT_CODE_PCM);
	assign fmt_bad_rng  = (rate_n > MAX_RATE) || (bits_n > MAX_BITS);
	assign fmt_ok       = fmt_done && !fmt_bad_code && !fmt_bad_rng;
	assign skip_done    = (phase_q == PH_SKIP) && (cnt_inc >= len_q);
	assign data_end     = (phase_q == PH_DATA) && (cnt_inc >= len_q);
	assign smp_emit     = (phase_q == PH_DATA) && ((bits_q != MAX_BITS) || cnt_q[0]);

	// finish raised by the byte itself
	assign fin_a = (hdr_done && tag_n == TAG_DATA && len_n == 32'd0)
		|| (fmt_done && !fmt_ok) || data_end;
	// the byte leaves the parser inside a data chunk
	assign mid_data = ((phase_q == PH_DATA) && !data_end) || (hdr_done && tag_n == TAG_DATA);
	assign mid_have = have_q | fmt_ok;
	assign eof_fin  = eof && !fin_a && (phase_q != PH_DONE);

	always_comb begin
		if (fmt_done && fmt_bad_code)
			st_a = ST_NOT_PCM;
		else if (fmt_done)
			st_a = ST_RANGE;
		else
			st_a = have_q ? ST_OK : ST_NO_FORMAT;
		if (mid_data)
			st_e = mid_have ? ST_OK : ST_NO_FORMAT;
		else
			st_e = mid_have ? ST_NO_DATA : ST_NO_FORMAT;
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_inc;
		len_d   = len_n;
		have_n  = have_q;
		case (phase_q)
			PH_PREAMBLE: begin
				if (pre_done) begin
					phase_n = PH_HEADER;
					cnt_n   = '0;
				end
			end
			PH_HEADER: begin
				if (hdr_done) begin
					cnt_n = '0;
					if (tag_n == TAG_FMT)
						phase_n = PH_FMT;
					else if (tag_n == TAG_DATA)
						phase_n = (len_n == 32'd0) ? PH_DONE : PH_DATA;
					else
						phase_n = (len_n == 32'd0) ? PH_HEADER : PH_SKIP;
				end
			end
			PH_FMT: begin
				if (fmt_done) begin
					cnt_n = '0;
					if (!fmt_ok) begin
						phase_n = PH_DONE;
					end else begin
						have_n = 1'b1;
						if (len_n > FMT_BODY_LEN) begin
							len_d   = len_n - FMT_BODY_LEN;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_HEADER;
						end
					end
				end
			end
			PH_SKIP: begin
				if (skip_done) begin
					phase_n = PH_HEADER;
					cnt_n   = '0;
				end
			end
			PH_DATA: begin
				if (data_end)
					phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
				cnt_n   = cnt_q;
			end
		endcase
		if (eof_fin)
			phase_n = PH_DONE;
	end

	// results
	always_comb begin
		res_t prim, stat;
		logic [15:0] hi16, dac;
		logic        rnd, has_prim, has_stat;
		hi16 = {{8{in_byte[7]}}, in_byte};
		rnd  = in_byte[7] && (low_q != 8'd0);
		dac  = hi16 + {15'b0, rnd} + SMP_OFFSET;

		prim = '0;
		if (fmt_ok) begin
			prim.kind     = KIND_FORMAT;
			prim.channels = chan_n;
			prim.rate     = rate_n[15:0];
			prim.bits     = bits_n[4:0];
		end else begin
			prim.kind = KIND_SAMPLE;
			if (bits_q == MAX_BITS)
				prim.sample = mode ? {in_byte, low_q} : dac;
			else
				prim.sample = mode ? {in_byte ^ 8'h80, 8'h00} : {8'h00, in_byte};
		end

		stat        = '0;
		stat.kind   = KIND_STATUS;
		stat.last   = 1'b1;
		stat.status = fin_a ? st_a : st_e;

		has_prim = smp_emit || fmt_ok;
		has_stat = fin_a || eof_fin;
		res0     = has_prim ? prim : stat;
		res1     = stat;
		res_cnt  = step_en ? (2'({1'b0, has_prim}) + 2'({1'b0, has_stat})) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREAMBLE;
			cnt_q   <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			code_q  <= '0;
			chan_q  <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			low_q   <= '0;
			have_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			tag_q   <= tag_n;
			len_q   <= len_d;
			code_q  <= code_n;
			chan_q  <= chan_n;
			rate_q  <= rate_n;
			bits_q  <= bits_n;
			low_q   <= low_n;
			have_q  <= have_n;
		end
	end

endmodule

// File: rtl/wcp_result_fifo.sv
module wcp_result_fifo #(
	parameter int DEPTH = wcp_pkg::RES_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_cnt,
	input  wcp_pkg::res_t push_d0,
	input  wcp_pkg::res_t push_d1,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output wcp_pkg::res_t out_data
);
	import wcp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_p1;
	logic [CW-1:0] cnt_q;
	logic          pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_p1     = ptr_next(wr_q);
	assign room      = (cnt_q <= CW'(DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_q] <= push_d0;
		if (push_cnt == 2'd2)
			mem_q[wr_p1] <= push_d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_cnt == 2'd1)
				wr_q <= wr_p1;
			else if (push_cnt == 2'd2)
				wr_q <= ptr_next(wr_p1);
			if (pop)
				rd_q <= ptr_next(rd_q);
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

// File: rtl/wave_chunk_parser_pcm_convert.sv
// Channel   Dir  Payload                                          Marks
// s_axis    in   tdata[7:0] file byte                             tlast = last byte of file
// m_axis    out  tdata sample/channels/rate/bits/status           tuser = kind, tlast = final
// cfg       in   cfg_wdata = output mode (0 DAC 8-bit, 1 16-bit)  write on cfg_we
//
// A byte is registered on acceptance and parsed from that register; its words enter the
// result queue at the edge at which the input stage advances, which waits for queue room.
// One byte per cycle is sustained while results drain at one word per cycle; a byte makes
// at most two words, so hold the input stage while the queue holds more than two.
// Reset clears the parse phase, all chunk fields and the output mode to DAC mode.
// After the final status word every further byte is taken and dropped.
module wave_chunk_parser_pcm_convert #(
	parameter int RES_DEPTH = wcp_pkg::RES_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// stream in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [wcp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] in_byte
	input  logic                               s_axis_tlast,  // end_of_file
	// stream out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [15:0] sample, [31:16] channels, [47:32] rate,
	// [52:48] bit depth, [55:53] status
	output logic [wcp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic [1:0]                         m_axis_tuser,  // [1:0] kind
	output logic                               m_axis_tlast,  // last
	// configuration
	input  logic                               cfg_we,
	input  logic                               cfg_wdata      // output_mode
);
	import wcp_pkg::*;

	// input stage
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       step_en;
	logic       s_fire;

	logic       mode_q;

	res_t       res0, res1, head;
	logic [1:0] res_cnt;
	logic       room;

	// Advance the input stage only when the queue can take a full two-word burst.
	assign step_en       = v_s1 && room;
	assign s_axis_tready = !v_s1 || step_en;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			if (s_fire)
				v_s1 <= 1'b1;
			else if (step_en)
				v_s1 <= 1'b0;
			if (cfg_we)
				mode_q <= cfg_wdata;
		end
	end

	// Hold the byte payload; no reset needed since v_s1 qualifies it.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_axis_tdata[7:0];
			eof_s1  <= s_axis_tlast;
		end
	end

	wcp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.in_byte (byte_s1),
		.eof     (eof_s1),
		.mode    (mode_q),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	wcp_result_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (res_cnt),
		.push_d0   (res0),
		.push_d1   (res1),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (head)
	);

	// Pack the queue head, highest field first.
	assign m_axis_tdata = {head.status, head.bits, head.rate, head.channels, head.sample};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

// File: rtl/wcp_checker.sv
`include "wave_chunk_parser_pcm_convert_defines.svh"

module wcp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [wcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                      m_axis_tuser,
	input logic                            m_axis_tlast
);
	import wcp_pkg::*;

	`WCP_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")
	`WCP_ASSERT_IMP(a_last_kind, clk, arst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == KIND_STATUS), "tlast does not match status kind")
	`WCP_ASSERT_NXT(a_after_last, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "word after final status")
	`WCP_ASSERT_IMP(a_fmt_range, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_FORMAT, m_axis_tdata[55:53] == 3'd0 && m_axis_tdata[52:48] <= 5'd16 && {16'd0, m_axis_tdata[47:32]} <= MAX_RATE, "format word out of range")

endmodule

bind wave_chunk_parser_pcm_convert wcp_checker u_wcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
